/* hdl/hmt_pkg.sv */
// Shared types and constants of the heartbeat membership table.
// Used by the channel interfaces, the table memory and the top level.
package hmt_pkg;

    localparam int MAX_OUT = 32;
    localparam int NW      = 6;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_JOIN  = 2'd0;
    localparam t_cmd CMD_MERGE = 2'd1;
    localparam t_cmd CMD_TICK  = 2'd2;
    localparam t_cmd CMD_LIST  = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_UPDATED  = 3'd1;
    localparam t_status ST_IGNORED  = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_TICK     = 3'd4;
    localparam t_status ST_LIVE     = 3'd5;
    localparam t_status ST_NONE     = 3'd6;

    typedef logic [1:0] t_reg;
    localparam t_reg REG_FAIL      = 2'd0;
    localparam t_reg REG_REMOVE    = 2'd1;
    localparam t_reg REG_SELF_ID   = 2'd2;
    localparam t_reg REG_SELF_PORT = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] hb;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] member_id;
        logic [15:0] member_port;
        logic [31:0] member_heartbeat;
        logic [31:0] member_time;
        logic [31:0] current_time;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [31:0] entry_id;
        logic [15:0] entry_port;
        logic [31:0] entry_heartbeat;
        logic [31:0] entry_time;
        logic [4:0]  removed_count;
        logic        last;
    } t_out_beat;

endpackage

/* hdl/hmt_in_if.sv */
// Input channel of the membership table: valid, ready and one command beat.
// Depends on hmt_pkg for the beat type.
interface hmt_in_if import hmt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/hmt_out_if.sv */
// Result channel of the membership table: valid, ready and one result beat.
// Depends on hmt_pkg for the beat type.
interface hmt_out_if import hmt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/hmt_ram.sv */
// Peer entry memory: one write port, one read port with registered data.
// Depends on hmt_pkg for the entry type.
module hmt_ram import hmt_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);
    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/heartbeat_membership_table.sv */
// Top level of the heartbeat membership table: sequencer, slot zero and registers.
// Depends on hmt_pkg, hmt_in_if, hmt_out_if and hmt_ram.
//
// Channel   Dir  Handshake       Beat
// i_cmd     in   valid/ready     t_in_beat (command and member fields)
// o_res     out  valid/ready     t_out_beat (status, entry fields, last)
// i_cfg     in   write enable    register index and 32-bit data
//
// Join, merge and list walk slots 0 to used_count - 1 one per cycle through the single
// read port; a tick skips slot zero. A new command is accepted only once its result beat is loaded.
// A list stalls its walk while a result beat waits in the output register.
// Reset restores slot zero and the registers at once; no clearing pass is run.
module heartbeat_membership_table import hmt_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hmt_in_if.sink          i_cmd,
    hmt_out_if.source       o_res,
    input  logic            i_cfg_we,
    input  t_reg            i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [31:0] r_mid, r_mhb, r_mtime, r_now;
    logic [15:0] r_mport;
    logic [31:0] r_fail, r_rem, r_self_id, n_self_id;
    logic [15:0] r_self_port, n_self_port;
    logic [31:0] n_fail, n_rem;
    logic [31:0] r_own, n_own, r_hb0, n_hb0, r_st0, n_st0;
    logic [CW-1:0] r_used, n_used, r_idx, n_idx, r_pidx, n_pidx, r_w, n_w;
    logic r_pv, n_pv;
    logic [4:0] r_removed, n_removed;
    logic r_found, n_found;
    logic [CW-1:0] r_fslot, n_fslot;
    logic [31:0] r_fhb, n_fhb, r_fst, n_fst;
    logic r_hold_v, n_hold_v;
    t_entry r_hold, n_hold;
    logic [NW-1:0] r_n, n_n;
    logic r_ov, n_ov;
    t_out_beat r_o, n_o;

    logic mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry mem_wdata, mem_rdata;

    t_entry w_ent;
    logic [31:0] w_age;
    logic w_live, w_can_out, w_go, w_more, w_hit, w_cap, w_issue, w_accept;

    hmt_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && (r_state == S_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_o;

    assign w_ent = (r_pidx == '0) ? t_entry'{id: r_self_id, port: r_self_port, hb: r_hb0,
                                             stamp: r_st0} : mem_rdata;
    assign w_age     = r_now - w_ent.stamp;
    assign w_live    = w_age < r_fail;
    assign w_can_out = !r_ov || o_res.ready;
    assign w_go      = (r_cmd != CMD_LIST) || w_can_out;
    assign w_more    = r_idx < r_used;
    assign w_hit     = r_pv && (r_cmd == CMD_JOIN || r_cmd == CMD_MERGE)
                       && w_ent.id == r_mid && w_ent.port == r_mport;
    assign w_cap     = r_pv && (r_cmd == CMD_LIST) && w_live
                       && (r_n == NW'(MAX_OUT - 1));
    assign w_issue   = (r_state == S_SCAN) && w_go && w_more && !w_hit && !w_cap;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_go && (w_hit || w_cap || (!r_pv && !w_more))) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_can_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_self_id = r_self_id;
        n_self_port = r_self_port;
        n_fail = r_fail;
        n_rem = r_rem;
        n_own = r_own;
        n_hb0 = r_hb0;
        n_st0 = r_st0;
        n_used = r_used;
        n_idx = r_idx;
        n_pidx = r_pidx;
        n_w = r_w;
        n_pv = r_pv;
        n_removed = r_removed;
        n_found = r_found;
        n_fslot = r_fslot;
        n_fhb = r_fhb;
        n_fst = r_fst;
        n_hold_v = r_hold_v;
        n_hold = r_hold;
        n_n = r_n;
        n_ov = r_ov && !o_res.ready;
        n_o = r_o;
        mem_we = 1'b0;
        mem_waddr = r_w[AW-1:0];
        mem_wdata = w_ent;
        mem_re = 1'b0;
        mem_raddr = r_idx[AW-1:0];

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FAIL:      n_fail = i_cfg_data;
                REG_REMOVE:    n_rem = i_cfg_data;
                REG_SELF_ID:   n_self_id = i_cfg_data;
                REG_SELF_PORT: n_self_port = i_cfg_data[15:0];
                default:       n_fail = r_fail;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pv = 1'b0;
                    n_found = 1'b0;
                    n_hold_v = 1'b0;
                    n_n = '0;
                    n_removed = '0;
                    n_w = CW'(1);
                    n_idx = '0;
                    if (i_cmd.data.command == CMD_TICK) begin
                        n_own = r_own + 32'd1;
                        n_hb0 = r_own + 32'd1;
                        n_st0 = i_cmd.data.current_time;
                        n_idx = CW'(1);
                    end
                end
            end
            S_SCAN: begin
                if (w_go) begin
                    mem_re = w_issue;
                    n_pv = w_issue;
                    if (w_issue) begin
                        n_idx = r_idx + CW'(1);
                        n_pidx = r_idx;
                    end
                    if (r_pv) begin
                        case (r_cmd)
                            CMD_TICK: begin
                                if (w_age >= r_rem) begin
                                    n_removed = (r_removed == 5'd31) ? 5'd31
                                                                     : r_removed + 5'd1;
                                end else begin
                                    mem_we = 1'b1;
                                    n_w = r_w + CW'(1);
                                end
                            end
                            CMD_LIST: begin
                                if (w_live) begin
                                    if (r_hold_v) begin
                                        n_ov = 1'b1;
                                        n_o = '{status: ST_LIVE, entry_id: r_hold.id,
                                                entry_port: r_hold.port,
                                                entry_heartbeat: r_hold.hb,
                                                entry_time: r_hold.stamp,
                                                removed_count: 5'd0, last: 1'b0};
                                    end
                                    n_hold_v = 1'b1;
                                    n_hold = w_ent;
                                    n_n = r_n + NW'(1);
                                end
                            end
                            default: begin
                                if (w_hit) begin
                                    n_found = 1'b1;
                                    n_fslot = r_pidx;
                                    n_fhb = w_ent.hb;
                                    n_fst = w_ent.stamp;
                                end
                            end
                        endcase
                    end
                end
            end
            S_FINISH: begin
                if (w_can_out) begin
                    n_ov = 1'b1;
                    n_o = '0;
                    n_o.last = 1'b1;
                    mem_wdata = '{id: r_mid, port: r_mport, hb: r_mhb, stamp: r_now};
                    mem_waddr = r_used[AW-1:0];
                    case (r_cmd)
                        CMD_TICK: begin
                            n_used = r_w;
                            n_o.status = ST_TICK;
                            n_o.removed_count = r_removed;
                        end
                        CMD_LIST: begin
                            n_hold_v = 1'b0;
                            if (r_hold_v) begin
                                n_o = '{status: ST_LIVE, entry_id: r_hold.id,
                                        entry_port: r_hold.port, entry_heartbeat: r_hold.hb,
                                        entry_time: r_hold.stamp, removed_count: 5'd0,
                                        last: 1'b1};
                            end else begin
                                n_o.status = ST_NONE;
                            end
                        end
                        default: begin
                            if (r_cmd == CMD_MERGE) begin
                                mem_wdata.stamp = r_mtime;
                            end
                            if (r_found) begin
                                n_o.status = ST_IGNORED;
                                if (r_cmd == CMD_MERGE && r_mhb > r_fhb
                                    && (r_now - r_fst) < r_fail) begin
                                    n_o.status = ST_UPDATED;
                                    mem_wdata.stamp = r_now;
                                    mem_waddr = r_fslot[AW-1:0];
                                    if (r_fslot == '0) begin
                                        n_hb0 = r_mhb;
                                        n_st0 = r_now;
                                    end else begin
                                        mem_we = 1'b1;
                                    end
                                end
                            end else if (r_used < CW'(TABLE_DEPTH)) begin
                                n_o.status = ST_INSERTED;
                                mem_we = 1'b1;
                                n_used = r_used + CW'(1);
                            end else begin
                                n_o.status = ST_FULL;
                            end
                        end
                    endcase
                end
            end
            default: n_pv = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fail <= 32'd5;
            r_rem <= 32'd20;
            r_self_id <= 32'd1;
            r_self_port <= 16'd0;
            r_own <= '0;
            r_hb0 <= '0;
            r_st0 <= '0;
            r_used <= CW'(1);
            r_pv <= 1'b0;
            r_hold_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fail <= n_fail;
            r_rem <= n_rem;
            r_self_id <= n_self_id;
            r_self_port <= n_self_port;
            r_own <= n_own;
            r_hb0 <= n_hb0;
            r_st0 <= n_st0;
            r_used <= n_used;
            r_pv <= n_pv;
            r_hold_v <= n_hold_v;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd.data.command;
            r_mid <= i_cmd.data.member_id;
            r_mport <= i_cmd.data.member_port;
            r_mhb <= i_cmd.data.member_heartbeat;
            r_mtime <= i_cmd.data.member_time;
            r_now <= i_cmd.data.current_time;
        end
        r_idx <= n_idx;
        r_pidx <= n_pidx;
        r_w <= n_w;
        r_removed <= n_removed;
        r_found <= n_found;
        r_fslot <= n_fslot;
        r_fhb <= n_fhb;
        r_fst <= n_fst;
        r_hold <= n_hold;
        r_n <= n_n;
        r_o <= n_o;
    end

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used != '0 && r_used <= CW'(TABLE_DEPTH))
        else $error("used count out of range");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pv)
        else $error("pending read while idle");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmd == CMD_TICK && r_pv) |-> r_w <= r_pidx)
        else $error("compaction write overtook the read");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready) |=> $stable(r_o))
        else $error("waiting result beat overwritten");
endmodule
